### rtl/nearest_codebook_search_macros.svh
// Assertion macros for the nearest codebook search block.
// The using module must have signals named clk and rst_n in scope.
`ifndef NEAREST_CODEBOOK_SEARCH_MACROS_SVH
`define NEAREST_CODEBOOK_SEARCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NCS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ncs_pkg.sv
// Package for the nearest codebook search block: sizes, register codes,
// request and result structs and the sequencer state type. No dependencies.
`default_nettype none

package ncs_pkg;

    // Codebook and vector sizes.
    localparam int MAX_NODES   = 256;
    localparam int MAX_DIMS    = 32;
    localparam int VALUE_BITS  = 16;
    localparam int NODE_BITS   = $clog2(MAX_NODES);
    localparam int DIM_BITS    = $clog2(MAX_DIMS);
    localparam int NCOUNT_BITS = $clog2(MAX_NODES + 1);
    localparam int DCOUNT_BITS = $clog2(MAX_DIMS + 1);
    localparam int ADDR_BITS   = NODE_BITS + DIM_BITS;
    localparam int CB_DEPTH    = MAX_NODES * MAX_DIMS;
    localparam int DIFF_BITS   = VALUE_BITS + 1;
    localparam int SQ_BITS     = 2 * VALUE_BITS;
    localparam int DIST_BITS   = 37;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 9;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_COUNT  = 2'd1;

    // Reset values of the registers.
    localparam logic [NCOUNT_BITS-1:0] NODE_COUNT_RESET = NCOUNT_BITS'(MAX_NODES);
    localparam logic [DCOUNT_BITS-1:0] DIM_COUNT_RESET  = DCOUNT_BITS'(MAX_DIMS);

    // Request modes.
    localparam logic MODE_CODEBOOK = 1'b0;
    localparam logic MODE_QUERY    = 1'b1;

    typedef struct packed {
        logic                         mode;
        logic [7:0]                   node_index;
        logic [4:0]                   feature_index;
        logic signed [VALUE_BITS-1:0] value;
        logic [7:0]                   hint_node;
        logic                         last;
    } request_t;

    typedef struct packed {
        logic [7:0]           winner_node;
        logic [DIST_BITS-1:0] best_distance;
        logic                 hint_invalid;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

endpackage

`default_nettype wire

### rtl/nearest_codebook_search.sv
// Nearest codebook search: best-matching-node search over a codebook memory.
// A write request is stored when it is accepted; a search reads nodes*dims element pairs,
// then drains the pipeline before the result strobe (no reads when dim_count is 0).
// Throughput: one codebook element per cycle, set by the single codebook read port.
// The receiver cannot stall; each result is shown for one cycle only.
// Reset clears control state and the registers to 256 nodes and 32 elements.
`default_nettype none
`include "nearest_codebook_search_macros.svh"

module nearest_codebook_search
    import ncs_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output      logic                      busy,
    input  wire request_t                  request,
    input  wire logic                      cfg_valid,
    output      logic                      cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    output      logic                      result_valid,
    output      result_t                   result
);

    // Memories.
    logic signed [VALUE_BITS-1:0] codebook_mem [CB_DEPTH];
    logic signed [VALUE_BITS-1:0] query_mem [MAX_DIMS];
    logic signed [VALUE_BITS-1:0] cb_q_reg;
    logic signed [VALUE_BITS-1:0] qb_q_reg;

    // Configuration registers.
    logic [NCOUNT_BITS-1:0] node_count_reg;
    logic [DCOUNT_BITS-1:0] dim_count_reg;

    // Sequencer state.
    state_t                 state_reg, state_next;
    logic [NODE_BITS-1:0]   node_reg, node_next;
    logic [DIM_BITS-1:0]    dim_reg, dim_next;
    logic                   first_reg, first_next;
    logic [NCOUNT_BITS-1:0] nodes_reg, nodes_next;
    logic [DCOUNT_BITS-1:0] dims_reg, dims_next;
    logic [NODE_BITS-1:0]   start_reg, start_next;
    logic                   invalid_reg, invalid_next;
    logic                   res_valid_reg, res_valid_next;

    // Pipeline tags and data.
    logic                   s1_valid_reg, s1_first_reg, s1_lastel_reg;
    logic [NODE_BITS-1:0]   s1_node_reg;
    logic                   s2_valid_reg, s2_first_reg, s2_lastel_reg;
    logic [NODE_BITS-1:0]   s2_node_reg;
    logic [SQ_BITS-1:0]     sq_reg;
    logic                   s3_valid_reg, s3_lastel_reg;
    logic [NODE_BITS-1:0]   s3_node_reg;
    logic [DIST_BITS-1:0]   acc_reg;
    logic                   best_valid_reg;
    logic [DIST_BITS-1:0]   best_reg;
    logic [NODE_BITS-1:0]   best_node_reg;

    // Combinational helpers.
    logic                   accept;
    logic                   search_go;
    logic                   issue;
    logic                   issue_lastel;
    logic [NCOUNT_BITS-1:0] nodes_eff;
    logic [DCOUNT_BITS-1:0] dims_eff;
    logic                   hint_bad;
    logic [NCOUNT_BITS-1:0] scan_base;
    logic [NCOUNT_BITS-1:0] scan_cand;
    logic signed [DIFF_BITS-1:0]   diff;
    logic signed [2*DIFF_BITS-1:0] prod;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign accept    = start && !busy;
    assign search_go = accept && (request.mode == MODE_QUERY) && request.last;
    assign issue     = (state_reg == ST_SCAN);
    assign issue_lastel = ({1'b0, dim_reg} == (dims_reg - DCOUNT_BITS'(1)));

    // Saturated register values and hint check for a new search.
    always_comb
    begin
        if (node_count_reg == '0)
            nodes_eff = NCOUNT_BITS'(1);
        else if (node_count_reg > NCOUNT_BITS'(MAX_NODES))
            nodes_eff = NCOUNT_BITS'(MAX_NODES);
        else
            nodes_eff = node_count_reg;
        if (dim_count_reg > DCOUNT_BITS'(MAX_DIMS))
            dims_eff = DCOUNT_BITS'(MAX_DIMS);
        else
            dims_eff = dim_count_reg;
        hint_bad = ({1'b0, request.hint_node} >= nodes_eff);
    end

    // Next node to scan after the current one, skipping the starting node.
    always_comb
    begin
        if (first_reg)
            scan_base = '0;
        else
            scan_base = {1'b0, node_reg} + NCOUNT_BITS'(1);
        if (scan_base == {1'b0, start_reg})
            scan_cand = scan_base + NCOUNT_BITS'(1);
        else
            scan_cand = scan_base;
    end

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
            dim_count_reg  <= DIM_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_NODE_COUNT: node_count_reg <= cfg_data[NCOUNT_BITS-1:0];
                REG_DIM_COUNT:  dim_count_reg  <= cfg_data[DCOUNT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Codebook memory: written by codebook requests, read by the scan.
    always_ff @(posedge clk)
    begin
        if (accept && (request.mode == MODE_CODEBOOK))
            codebook_mem[{request.node_index, request.feature_index}] <= request.value;
        cb_q_reg <= codebook_mem[{node_reg, dim_reg}];
    end

    // Query memory: written by query requests, read alongside the codebook.
    always_ff @(posedge clk)
    begin
        if (accept && (request.mode == MODE_QUERY))
            query_mem[request.feature_index] <= request.value;
        qb_q_reg <= query_mem[dim_reg];
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            node_reg      <= '0;
            dim_reg       <= '0;
            first_reg     <= 1'b0;
            nodes_reg     <= '0;
            dims_reg      <= '0;
            start_reg     <= '0;
            invalid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            node_reg      <= node_next;
            dim_reg       <= dim_next;
            first_reg     <= first_next;
            nodes_reg     <= nodes_next;
            dims_reg      <= dims_next;
            start_reg     <= start_next;
            invalid_reg   <= invalid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Sequencer next state: starting node first, then all others in order.
    always_comb
    begin
        state_next     = state_reg;
        node_next      = node_reg;
        dim_next       = dim_reg;
        first_next     = first_reg;
        nodes_next     = nodes_reg;
        dims_next      = dims_reg;
        start_next     = start_reg;
        invalid_next   = invalid_reg;
        res_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (search_go)
                begin
                    nodes_next   = nodes_eff;
                    dims_next    = dims_eff;
                    invalid_next = hint_bad;
                    start_next   = hint_bad ? '0 : request.hint_node;
                    node_next    = hint_bad ? '0 : request.hint_node;
                    dim_next     = '0;
                    first_next   = 1'b1;
                    state_next   = (dims_eff == '0) ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue_lastel)
                begin
                    dim_next   = '0;
                    first_next = 1'b0;
                    if (scan_cand >= nodes_reg)
                        state_next = ST_DRAIN;
                    else
                        node_next = scan_cand[NODE_BITS-1:0];
                end
                else
                begin
                    dim_next = dim_reg + DIM_BITS'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg && !s3_valid_reg)
                begin
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Pipeline valid flags and the best-so-far flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (search_go)
                best_valid_reg <= (dims_eff == '0);
            else if (s3_valid_reg && s3_lastel_reg)
                best_valid_reg <= 1'b1;
        end
    end

    // Difference and square of one element pair.
    assign diff = DIFF_BITS'(cb_q_reg) - DIFF_BITS'(qb_q_reg);
    assign prod = diff * diff;

    // Pipeline payload: square, accumulate, compare with the best.
    always_ff @(posedge clk)
    begin
        s1_first_reg  <= (dim_reg == '0);
        s1_lastel_reg <= issue_lastel;
        s1_node_reg   <= node_reg;

        s2_first_reg  <= s1_first_reg;
        s2_lastel_reg <= s1_lastel_reg;
        s2_node_reg   <= s1_node_reg;
        sq_reg        <= prod[SQ_BITS-1:0];

        s3_lastel_reg <= s2_lastel_reg;
        s3_node_reg   <= s2_node_reg;
        if (s2_valid_reg)
        begin
            if (s2_first_reg)
                acc_reg <= DIST_BITS'(sq_reg);
            else
                acc_reg <= acc_reg + DIST_BITS'(sq_reg);
        end

        if (search_go)
        begin
            best_reg      <= '0;
            best_node_reg <= hint_bad ? '0 : request.hint_node;
        end
        else if (s3_valid_reg && s3_lastel_reg)
        begin
            if (!best_valid_reg || (acc_reg < best_reg))
            begin
                best_reg      <= acc_reg;
                best_node_reg <= s3_node_reg;
            end
        end
    end

    // Result outputs.
    assign result_valid         = res_valid_reg;
    assign result.winner_node   = best_node_reg;
    assign result.best_distance = best_reg;
    assign result.hint_invalid  = invalid_reg;

    // Assertions.
    `NCS_ASSERT_SAME(a_result_when_idle, res_valid_reg, state_reg == ST_IDLE,
        "result strobe outside idle state")
    `NCS_ASSERT_SAME(a_accept_pipe_empty, accept,
        !s1_valid_reg && !s2_valid_reg && !s3_valid_reg,
        "request accepted while the pipeline holds data")
    `NCS_ASSERT_NEXT(a_result_one_cycle, res_valid_reg, !res_valid_reg,
        "result strobe longer than one cycle")
    `NCS_ASSERT_SAME(a_dim_in_range, state_reg == ST_SCAN,
        ({1'b0, dim_reg} < dims_reg) && ({1'b0, node_reg} < nodes_reg),
        "scan address beyond the configured vector or node count")

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking bench for nearest_codebook_search: loads codebook elements,
// sends query vectors, predicts each best match and checks every result strobe.
// Depends on ncs_pkg and the nearest_codebook_search RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ncs_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int LIMIT_CYCLES  = 1000000;
    // No pending search means only a memory write can be in flight.
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;
    localparam longint unsigned DIST_CEIL = (64'd1 << DIST_BITS) - 64'd1;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    request_t                  request;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      result_valid;
    result_t                   result;

    // Bench copy of the block's state and registers.
    bit signed [VALUE_BITS-1:0] codebook_copy [MAX_NODES*MAX_DIMS];
    bit signed [VALUE_BITS-1:0] query_copy [MAX_DIMS];
    bit                         codebook_loaded [MAX_NODES*MAX_DIMS];
    bit                         query_loaded [MAX_DIMS];
    bit [NCOUNT_BITS-1:0]       node_count_cfg = NODE_COUNT_RESET;
    bit [DCOUNT_BITS-1:0]       dim_count_cfg = DIM_COUNT_RESET;

    result_t pending_matches [$];

    int mismatches      = 0;
    int requests_sent   = 0;
    int matches_checked = 0;
    int reg_writes      = 0;
    int map_sizes       = 0;
    int cycle_count     = 0;
    int burst_left      = 0;

    nearest_codebook_search uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_matches.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Register values as the block uses them: saturated into range.
    function automatic int effective_nodes();
        int nodes;
        nodes = node_count_cfg;
        if (nodes > MAX_NODES)
            nodes = MAX_NODES;
        if (nodes < 1)
            nodes = 1;
        return nodes;
    endfunction

    function automatic int effective_dims();
        int dims;
        dims = dim_count_cfg;
        if (dims > MAX_DIMS)
            dims = MAX_DIMS;
        return dims;
    endfunction

    function automatic longint unsigned squared_distance(int node, int dims);
        longint unsigned acc;
        longint          diff;
        acc = 0;
        for (int d = 0; d < dims; d++)
        begin
            diff = longint'(codebook_copy[node*MAX_DIMS + d]) - longint'(query_copy[d]);
            acc += longint'(diff * diff);
        end
        return acc;
    endfunction

    // Hint first, then every other node in index order; only a strictly
    // smaller distance takes over.
    function automatic result_t best_match(logic [7:0] hint);
        result_t         match;
        int              nodes;
        int              dims;
        int              first;
        longint unsigned best;
        longint unsigned d2;
        nodes = effective_nodes();
        dims  = effective_dims();
        match.hint_invalid = (int'(hint) >= nodes);
        first = match.hint_invalid ? 0 : int'(hint);
        match.winner_node = 8'(first);
        best = squared_distance(first, dims);
        for (int n = 0; n < nodes; n++)
        begin
            if (n != first)
            begin
                d2 = squared_distance(n, dims);
                if (d2 < best)
                begin
                    best = d2;
                    match.winner_node = 8'(n);
                end
            end
        end
        if (best > DIST_CEIL)
            best = DIST_CEIL;
        match.best_distance = best[DIST_BITS-1:0];
        return match;
    endfunction

    // Result checker: every strobe is matched against the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (pending_matches.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result: winner %0d distance %0d invalid %0b",
                             $realtime, result.winner_node, result.best_distance,
                             result.hint_invalid);
            end
            else
            begin
                want = pending_matches.pop_front();
                matches_checked++;
                if (result.winner_node !== want.winner_node ||
                    result.best_distance !== want.best_distance ||
                    result.hint_invalid !== want.hint_invalid)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: mismatch: winner %0d/%0d distance %0d/%0d invalid %0b/%0b (expected/actual)",
                                 $realtime, want.winner_node, result.winner_node,
                                 want.best_distance, result.best_distance,
                                 want.hint_invalid, result.hint_invalid);
                end
            end
        end
    end

    function automatic logic [VALUE_BITS-1:0] random_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return VALUE_BITS'($urandom);
        // Narrow values make equal distances common.
        if (pick < 8)
            return VALUE_BITS'($urandom_range(0, 6) - 3);
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Sends one request and updates the bench state once it is accepted.
    task automatic send_request(input logic mode, input logic [7:0] node,
                                input logic [4:0] feat, input logic [VALUE_BITS-1:0] value,
                                input logic [7:0] hint, input logic last);
        request_t item;
        item.mode          = mode;
        item.node_index    = node;
        item.feature_index = feat;
        item.value         = value;
        item.hint_node     = hint;
        item.last          = last;
        request <= item;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        requests_sent++;
        if (mode == MODE_CODEBOOK)
        begin
            codebook_copy[int'(node)*MAX_DIMS + int'(feat)]   = value;
            codebook_loaded[int'(node)*MAX_DIMS + int'(feat)] = 1'b1;
        end
        else
        begin
            query_copy[feat]   = value;
            query_loaded[feat] = 1'b1;
            if (last)
                pending_matches.push_back(best_match(hint));
        end
        // Sender pacing: bursts of random length, random gaps between them.
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Stops sending and lets every outstanding search finish.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] data);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
        if (index == REG_NODE_COUNT)
            node_count_cfg = data[NCOUNT_BITS-1:0];
        else if (index == REG_DIM_COUNT)
            dim_count_cfg = data[DCOUNT_BITS-1:0];
        @(posedge clk);
    endtask

    // Writes the map size while idle, sometimes with a write to an unused index.
    task automatic set_map_size(input int node_data, input int dim_data);
        wait_idle();
        if ($urandom_range(0, 2) == 0)
            write_register(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                           CFG_DATA_BITS'($urandom));
        write_register(REG_NODE_COUNT, CFG_DATA_BITS'(node_data));
        write_register(REG_DIM_COUNT, CFG_DATA_BITS'(dim_data));
        map_sizes++;
    endtask

    // Makes sure every element the search will read has been written.
    task automatic load_codebook_region();
        int nodes;
        int dims;
        nodes = effective_nodes();
        dims  = effective_dims();
        for (int n = 0; n < nodes; n++)
            for (int d = 0; d < dims; d++)
                if (!codebook_loaded[n*MAX_DIMS + d])
                    send_request(MODE_CODEBOOK, 8'(n), 5'(d), random_value(), 8'($urandom),
                                 1'($urandom_range(0, 3) == 0));
    endtask

    // One query vector in random order, some elements left out, the last one
    // carrying the hint. Elements never written are always delivered.
    task automatic send_query();
        int         feats [$];
        int         dims;
        int         nodes;
        int         j;
        int         tmp;
        logic [7:0] hint;
        dims  = effective_dims();
        nodes = effective_nodes();
        for (int d = 0; d < dims; d++)
            if (!query_loaded[d] || $urandom_range(0, 4) != 0)
                feats.push_back(d);
        if (dims < MAX_DIMS && $urandom_range(0, 3) == 0)
            feats.push_back($urandom_range(dims, MAX_DIMS - 1));
        if (feats.size() == 0)
            feats.push_back($urandom_range(0, MAX_DIMS - 1));
        for (int i = feats.size() - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = feats[i];
            feats[i] = feats[j];
            feats[j] = tmp;
        end
        hint = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, nodes - 1));
        for (int i = 0; i < feats.size(); i++)
            send_request(MODE_QUERY, 8'($urandom), 5'(feats[i]), random_value(),
                         (i == feats.size() - 1) ? hint : 8'($urandom),
                         i == feats.size() - 1);
    endtask

    // Mostly whole queries, mixed with codebook rewrites and stray requests.
    task automatic random_traffic(input int count);
        int stop;
        int pick;
        int nodes;
        int dims;
        stop  = requests_sent + count;
        nodes = effective_nodes();
        dims  = effective_dims();
        while (requests_sent < stop)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_query();
            else if (pick < 80 && dims > 0)
                send_request(MODE_CODEBOOK, 8'($urandom_range(0, nodes - 1)),
                             5'($urandom_range(0, dims - 1)), random_value(),
                             8'($urandom), 1'b0);
            else if (pick < 90)
                send_request(MODE_CODEBOOK, 8'($urandom), 5'($urandom), random_value(),
                             8'($urandom), 1'($urandom));
            else
                send_request(MODE_QUERY, 8'($urandom), 5'($urandom), random_value(),
                             8'($urandom), 1'b0);
        end
    endtask

    task automatic run_map_phase(input int node_data, input int dim_data, input int count);
        set_map_size(node_data, dim_data);
        load_codebook_region();
        random_traffic(count);
    endtask

    // Hand-picked requests on a three-node, two-element map.
    task automatic test_directed_cases();
        set_map_size(3, 2);
        send_request(MODE_CODEBOOK, 8'd0, 5'd0, 16'h7FFF, 8'd0, 1'b0);
        send_request(MODE_CODEBOOK, 8'd0, 5'd1, 16'h8000, 8'd0, 1'b0);
        send_request(MODE_CODEBOOK, 8'd1, 5'd0, 16'h0000, 8'd0, 1'b0);
        send_request(MODE_CODEBOOK, 8'd1, 5'd1, 16'h0000, 8'd0, 1'b0);
        send_request(MODE_CODEBOOK, 8'd2, 5'd0, 16'h0000, 8'd0, 1'b0);
        // Last on a codebook write must not start a search.
        send_request(MODE_CODEBOOK, 8'd2, 5'd1, 16'h0000, 8'hFF, 1'b1);
        send_request(MODE_CODEBOOK, 8'hFF, 5'h1F, 16'h5A5A, 8'hFF, 1'b0);
        // Hint ties with a lower node and keeps the win.
        send_request(MODE_QUERY, 8'd0, 5'd1, 16'h0000, 8'd0, 1'b0);
        send_request(MODE_QUERY, 8'd0, 5'd0, 16'h0000, 8'd2, 1'b1);
        // Invalid hint starts from node 0; the lowest tied index wins.
        send_request(MODE_QUERY, 8'hFF, 5'd0, 16'h8000, 8'hFF, 1'b1);
        // An element beyond the element count is stored but not used.
        send_request(MODE_QUERY, 8'd0, 5'h1F, 16'h7FFF, 8'd0, 1'b0);
        send_request(MODE_QUERY, 8'd0, 5'd1, 16'h7FFF, 8'd0, 1'b1);
        // One element delivered, the other kept; hint equal to the node count.
        send_request(MODE_QUERY, 8'd0, 5'd1, 16'h0001, 8'd3, 1'b1);
        // The search starts even when the last element is out of use.
        send_request(MODE_QUERY, 8'hFF, 5'h1F, 16'h8000, 8'd1, 1'b1);
    endtask

    // Node count of zero acts as one node; every element in use.
    task automatic test_single_node_full_dims();
        run_map_phase(0, 32, 40);
    endtask

    // With no elements in use every distance is zero, so the start node wins.
    task automatic test_zero_dims_full_map();
        run_map_phase(256, 0, 60);
        run_map_phase(511, 64, 60);
    endtask

    task automatic test_one_dim_full_map();
        run_map_phase(256, 1, 100);
    endtask

    // An element count above the maximum saturates to all elements.
    task automatic test_two_nodes_saturated_dims();
        run_map_phase(2, 45, 80);
    endtask

    task automatic test_random_small_maps();
        repeat (8)
            run_map_phase($urandom_range(1, 16), $urandom_range(1, 8), 70);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        request   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_single_node_full_dims();
        test_zero_dims_full_map();
        test_one_dim_full_map();
        test_two_nodes_saturated_dims();
        test_random_small_maps();
        wait_idle();

        $display("Sent %0d requests and checked %0d searches over %0d map sizes,",
                 requests_sent, matches_checked, map_sizes);
        $display("with %0d register writes and %0d mismatches.", reg_writes, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
